[rtl/core/tscd_pkg.sv]
package tscd_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_ACTIVE_THRESHOLD = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PAIR_WINDOW_MS   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HOLD_MS          = 2'd2;

   localparam logic [15:0] ActiveThresholdReset = 16'd1900;
   localparam logic [15:0] PairWindowReset      = 16'd2000;
   localparam logic [15:0] HoldMsReset          = 16'd5000;

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef struct packed {
      logic [15:0] active_threshold;
      logic [15:0] pair_window_ms;
      logic [15:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] ms_now;
      logic [31:0] edge_a_time;
      logic [31:0] edge_b_time;
      logic        edge_a_valid;
      logic        edge_b_valid;
      logic        prev_a_active;
      logic        prev_b_active;
      logic        paired_flag;
      logic        hold_active;
      logic [15:0] hold_left;
      logic        latched_flag;
   } state_type;

   typedef struct packed {
      logic req_type;
      logic [15:0] chan_a;
      logic [15:0] chan_b;
   } item_type;

   typedef struct packed {
      logic stop_fire;
      logic combo_paired;
      logic hold_running;
      logic stop_latched;
   } result_type;

endpackage

[rtl/core/tscd_step.sv]
module tscd_step (
   input  tscd_pkg::cfg_type    cfg,
   input  tscd_pkg::state_type  state_cur,
   input  tscd_pkg::item_type   item,
   output tscd_pkg::state_type  state_nxt,
   output tscd_pkg::result_type result
);

   logic        a_act;
   logic        b_act;
   logic        both;
   logic [31:0] d1;
   logic [31:0] d2;
   logic        in_window;
   logic        fire;
   tscd_pkg::state_type s;

   assign a_act = item.chan_a >= cfg.active_threshold;
   assign b_act = item.chan_b >= cfg.active_threshold;

   always_comb begin
      s         = state_cur;
      fire      = 1'b0;
      both      = 1'b0;
      d1        = '0;
      d2        = '0;
      in_window = 1'b0;
      if (item.req_type == tscd_pkg::REQ_TICK) begin
         s.ms_now = state_cur.ms_now + 32'd1;
         if (state_cur.hold_active) begin
            if (state_cur.hold_left > 16'd1) begin
               s.hold_left = state_cur.hold_left - 16'd1;
            end else begin
               s.hold_active = 1'b0;
               s.hold_left   = '0;
               if (!state_cur.latched_flag && state_cur.paired_flag &&
                   state_cur.prev_a_active && state_cur.prev_b_active) begin
                  fire           = 1'b1;
                  s.latched_flag = 1'b1;
                  s.paired_flag  = 1'b0;
                  s.edge_a_valid = 1'b0;
                  s.edge_b_valid = 1'b0;
               end
            end
         end
      end else begin
         if (a_act && !state_cur.prev_a_active) begin
            s.edge_a_time  = state_cur.ms_now;
            s.edge_a_valid = 1'b1;
         end
         if (b_act && !state_cur.prev_b_active) begin
            s.edge_b_time  = state_cur.ms_now;
            s.edge_b_valid = 1'b1;
         end
         s.prev_a_active = a_act;
         s.prev_b_active = b_act;
         both = s.edge_a_valid && s.edge_b_valid;
         d1   = s.edge_a_time - s.edge_b_time;
         d2   = s.edge_b_time - s.edge_a_time;
         // The smaller modular gap fits the window exactly when either one does.
         in_window = (d1 <= {16'd0, cfg.pair_window_ms}) ||
                     (d2 <= {16'd0, cfg.pair_window_ms});
         s.paired_flag = a_act && b_act && both && in_window;
         if (s.paired_flag) begin
            if (!s.hold_active && !s.latched_flag) begin
               s.hold_active = 1'b1;
               s.hold_left   = cfg.hold_ms;
            end
         end else if (s.hold_active) begin
            s.hold_active = 1'b0;
            s.hold_left   = '0;
         end
         if (!b_act && (s.hold_active || s.paired_flag || s.latched_flag)) begin
            s.latched_flag = 1'b0;
            s.paired_flag  = 1'b0;
            s.edge_a_valid = 1'b0;
            s.edge_b_valid = 1'b0;
            s.hold_active  = 1'b0;
            s.hold_left    = '0;
         end
      end
   end

   assign state_nxt           = s;
   assign result.stop_fire    = fire;
   assign result.combo_paired = s.paired_flag;
   assign result.hold_running = s.hold_active;
   assign result.stop_latched = s.latched_flag;

endmodule

[rtl/core/two_switch_combo_hold_detector_core.sv]
// Channel | Direction | Handshake              | Payload
// req     | in        | req_tvalid/req_tready  | tuser: req_type; tdata: chan_a, chan_b
// rsp     | out       | rsp_tvalid/rsp_tready  | tdata: stop_fire..stop_latched
// csr     | in        | csr_we (no wait)       | csr_index, csr_wdata
//
// Each request gives one response, held first in the input register and then in
// the response register. One request is taken per cycle while responses are
// drained. Reset restores the register defaults and clears the detector state and
// the valid flags. A stalled response holds the response register, and one more
// request can wait in the input register before req_tready drops.
module two_switch_combo_hold_detector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [31:0]                          req_tdata,  // chan_a, chan_b
   input  logic                                 req_tuser,  // req_type
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // stop_fire, combo_paired, hold_running, stop_latched, zero padding
   output logic [7:0]                           rsp_tdata,
   input  logic                                 csr_we,
   input  logic [tscd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tscd_pkg::CsrDataWidth-1:0]    csr_wdata
);

   tscd_pkg::cfg_type    cfg_ff;
   tscd_pkg::state_type  state_ff;
   tscd_pkg::state_type  state_in;
   tscd_pkg::item_type   item_ff;
   tscd_pkg::result_type result_in;
   tscd_pkg::result_type result_ff;
   logic                 item_valid_ff;
   logic                 advance;

   assign advance    = item_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   tscd_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_threshold <= tscd_pkg::ActiveThresholdReset;
         cfg_ff.pair_window_ms   <= tscd_pkg::PairWindowReset;
         cfg_ff.hold_ms          <= tscd_pkg::HoldMsReset;
      end else if (csr_we) begin
         case (csr_index)
            tscd_pkg::CSR_ACTIVE_THRESHOLD: cfg_ff.active_threshold <= csr_wdata;
            tscd_pkg::CSR_PAIR_WINDOW_MS:   cfg_ff.pair_window_ms   <= csr_wdata;
            tscd_pkg::CSR_HOLD_MS:          cfg_ff.hold_ms          <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         item_valid_ff <= 1'b0;
         rsp_tvalid    <= 1'b0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (advance) begin
            state_ff   <= state_in;
            rsp_tvalid <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.req_type <= req_tuser;
         item_ff.chan_a   <= req_tdata[15:0];
         item_ff.chan_b   <= req_tdata[31:16];
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tdata = {4'b0000, result_ff.stop_latched, result_ff.hold_running,
                       result_ff.combo_paired, result_ff.stop_fire};

endmodule
